[hw/rtl/fdssd_pkg.sv]
// Shared types, constants and the segment decoder for the four digit
// seven segment display driver. No dependencies.
package fdssd_pkg;

  // Display geometry
  localparam int DIGIT_COUNT = 4;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);

  // Register indexes on the configuration port
  localparam logic CFG_SHOW_LIMIT  = 1'b0;
  localparam logic CFG_DWELL_TICKS = 1'b1;

  // Reset values and limits
  localparam logic [13:0] SHOW_LIMIT_RESET = 14'd9999;
  localparam logic [13:0] MAX_SHOWN        = 14'd9999;
  localparam logic [15:0] DWELL_RESET      = 16'd100;

  // Item commands; code 3 is unused and leaves the state alone
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SHOW  = 2'd1;
  localparam logic [1:0] CMD_BLANK = 2'd2;

  // Digit codes beyond the decimal digits
  localparam logic [3:0] CODE_BLANK = 4'd10;
  localparam logic [3:0] CODE_E     = 4'd11;
  localparam logic [3:0] CODE_F     = 4'd12;
  localparam logic [3:0] CODE_R     = 4'd13;

  // Reciprocals for division by constants, exact for values up to 9999
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // 2^23 / 1000, rounded up
  localparam int          SHIFT_1000 = 23;
  localparam logic [12:0] RECIP_100  = 13'd5243;  // 2^19 / 100, rounded up
  localparam int          SHIFT_100  = 19;
  localparam logic [12:0] RECIP_10   = 13'd6554;  // 2^16 / 10, rounded up
  localparam int          SHIFT_10   = 16;

  // Decimal split of one item, handed from the split stage to the scan stage
  typedef struct packed {
    logic [1:0]  command;
    logic        err;      // value above the display limit
    logic [3:0]  q_th;     // value / 1000
    logic [6:0]  q_hu;     // value / 100
    logic [9:0]  q_te;     // value / 10
    logic [13:0] v_low;    // value, low bits
  } split_t;

  // Segment pattern: bit0 A .. bit6 G, bit7 point, 1 lit
  function automatic logic [7:0] seg_of(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:       seg = 8'h3F;
      4'd1:       seg = 8'h06;
      4'd2:       seg = 8'h5B;
      4'd3:       seg = 8'h4F;
      4'd4:       seg = 8'h66;
      4'd5:       seg = 8'h6D;
      4'd6:       seg = 8'h7D;
      4'd7:       seg = 8'h07;
      4'd8:       seg = 8'h7F;
      4'd9:       seg = 8'h6F;
      CODE_BLANK: seg = 8'h00;
      CODE_E:     seg = 8'h79;
      CODE_F:     seg = 8'h71;
      CODE_R:     seg = 8'h50;
      default:    seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

[hw/rtl/fdssd_cmd_if.sv]
// Command channel of the display driver: valid/ready with command and value.
// No dependencies.
interface fdssd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

[hw/rtl/fdssd_disp_if.sv]
// Display channel of the display driver: valid/ready with segment pattern,
// scanned digit and enable. No dependencies.
interface fdssd_disp_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [1:0] digit_index;
  logic       digit_enable;

  modport source (output valid, output segments, output digit_index,
                  output digit_enable, input ready);
  modport sink   (input valid, input segments, input digit_index,
                  input digit_enable, output ready);
endinterface

[hw/rtl/fdssd_split.sv]
// Input register and decimal split stage of the display driver.
// Depends on fdssd_pkg and fdssd_cmd_if.
module fdssd_split (
  input  logic               clk,
  input  logic               rst,
  fdssd_cmd_if.sink          cmd,
  input  logic [13:0]        show_limit,
  output logic               dn_valid,
  input  logic               dn_ready,
  output fdssd_pkg::split_t  dn_data
);

  logic        s1_valid;
  logic [1:0]  s1_command;
  logic [15:0] s1_value;
  logic        s1_ready;
  logic        s2_ready;

  logic [29:0] prod_th;
  logic [28:0] prod_hu;
  logic [28:0] prod_te;
  logic [13:0] limit;
  fdssd_pkg::split_t split_next;

  // Each stage moves on when the one after it is empty or draining
  assign s2_ready  = !dn_valid || dn_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign cmd.ready = s1_ready;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= cmd.valid;
    end
    if (s1_ready && cmd.valid) begin
      s1_command <= cmd.command;
      s1_value   <= cmd.value;
    end
  end

  // Quotients by reciprocal multiplication; the error compare uses the clamped limit
  always_comb begin
    prod_th = 30'(s1_value) * 30'(fdssd_pkg::RECIP_1000);
    prod_hu = 29'(s1_value) * 29'(fdssd_pkg::RECIP_100);
    prod_te = 29'(s1_value) * 29'(fdssd_pkg::RECIP_10);
    limit   = (show_limit > fdssd_pkg::MAX_SHOWN) ? fdssd_pkg::MAX_SHOWN : show_limit;

    split_next.command = s1_command;
    split_next.err     = {2'b00, limit} < s1_value;
    split_next.q_th    = prod_th[fdssd_pkg::SHIFT_1000 +: 4];
    split_next.q_hu    = prod_hu[fdssd_pkg::SHIFT_100 +: 7];
    split_next.q_te    = prod_te[fdssd_pkg::SHIFT_10 +: 10];
    split_next.v_low   = s1_value[13:0];
  end

  // Hold the split result for the scan stage
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (s2_ready) begin
      dn_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      dn_data <= split_next;
    end
  end

endmodule

[hw/rtl/four_digit_seven_segment_driver_unit.sv]
// Top level of the multiplexed four digit seven segment display driver.
// Depends on fdssd_pkg, fdssd_cmd_if, fdssd_disp_if and fdssd_split.
//
//   channel  dir  payload                                  handshake
//   cmd      in   command[1:0], value[15:0]                valid/ready
//   disp     out  segments[7:0], digit_index[1:0],         valid/ready
//                 digit_enable
//   cfg      in   cfg_index (0 show limit, 1 dwell ticks), cfg_we, no stall
//                 cfg_data[15:0]
//
// One transaction per cycle sustained while the output is not stalled; each result
// passes through the input register, the decimal split register and the
// result register. The scan and digit state update in the result stage, in
// command order. A stalled output backs up stage by stage; cmd.ready drops only
// when all three registers are full. Synchronous reset blanks all digits and
// restarts the scan.
module four_digit_seven_segment_driver_unit (
  input  logic        clk,
  input  logic        rst,
  fdssd_cmd_if.sink   cmd,
  fdssd_disp_if.source disp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [13:0] show_limit;
  logic [15:0] dwell_ticks;

  logic [3:0]  digit_codes [fdssd_pkg::DIGIT_COUNT];
  logic [3:0]  digit_codes_next [fdssd_pkg::DIGIT_COUNT];
  logic [fdssd_pkg::DIGIT_IDX_W-1:0] scan_pos;
  logic [fdssd_pkg::DIGIT_IDX_W-1:0] scan_pos_next;
  logic [15:0] dwell_count;
  logic [15:0] dwell_count_next;

  logic              sp_valid;
  logic              sp_ready;
  fdssd_pkg::split_t sp_data;

  logic [15:0] dwell_limit;
  logic [15:0] dwell_inc;
  logic [6:0]  hu_full;
  logic [9:0]  te_full;
  logic [13:0] un_full;
  logic        take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      show_limit  <= fdssd_pkg::SHOW_LIMIT_RESET;
      dwell_ticks <= fdssd_pkg::DWELL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fdssd_pkg::CFG_SHOW_LIMIT:  show_limit  <= cfg_data[13:0];
        fdssd_pkg::CFG_DWELL_TICKS: dwell_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  fdssd_split u_split (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .show_limit (show_limit),
    .dn_valid   (sp_valid),
    .dn_ready   (sp_ready),
    .dn_data    (sp_data)
  );

  assign sp_ready = !disp.valid || disp.ready;
  assign take     = sp_valid && sp_ready;

  // Work out the new digits, scan position and dwell count for one transaction
  always_comb begin
    hu_full = sp_data.q_hu - 7'(7'({3'd0, sp_data.q_th}) * 7'd10);
    te_full = sp_data.q_te - 10'(10'({3'd0, sp_data.q_hu}) * 10'd10);
    un_full = sp_data.v_low - 14'(14'({4'd0, sp_data.q_te}) * 14'd10);

    dwell_limit = (dwell_ticks == 16'd0) ? 16'd1 : dwell_ticks;
    dwell_inc   = dwell_count + 16'd1;

    digit_codes_next = digit_codes;
    scan_pos_next    = scan_pos;
    dwell_count_next = dwell_count;

    case (sp_data.command)
      fdssd_pkg::CMD_TICK: begin
        if (dwell_inc == 16'd0 || dwell_inc >= dwell_limit) begin
          dwell_count_next = 16'd0;
          scan_pos_next    = scan_pos + 1'b1;
        end else begin
          dwell_count_next = dwell_inc;
        end
      end
      fdssd_pkg::CMD_SHOW: begin
        if (sp_data.err) begin
          digit_codes_next[0] = fdssd_pkg::CODE_E;
          digit_codes_next[1] = fdssd_pkg::CODE_R;
          digit_codes_next[2] = fdssd_pkg::CODE_R;
          digit_codes_next[3] = fdssd_pkg::CODE_BLANK;
        end else begin
          // Blank leading zeros; the units digit always shows
          digit_codes_next[0] = (sp_data.q_th != 4'd0) ? sp_data.q_th
                                                       : fdssd_pkg::CODE_BLANK;
          digit_codes_next[1] = (sp_data.q_hu != 7'd0) ? hu_full[3:0]
                                                       : fdssd_pkg::CODE_BLANK;
          digit_codes_next[2] = (sp_data.q_te != 10'd0) ? te_full[3:0]
                                                        : fdssd_pkg::CODE_BLANK;
          digit_codes_next[3] = un_full[3:0];
        end
      end
      fdssd_pkg::CMD_BLANK: begin
        for (int i = 0; i < fdssd_pkg::DIGIT_COUNT; i++) begin
          digit_codes_next[i] = fdssd_pkg::CODE_BLANK;
        end
      end
      default: ;
    endcase
  end

  // Advance the display state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fdssd_pkg::DIGIT_COUNT; i++) begin
        digit_codes[i] <= fdssd_pkg::CODE_BLANK;
      end
      scan_pos     <= '0;
      dwell_count  <= 16'd0;
      disp.valid   <= 1'b0;
    end else begin
      if (sp_ready) begin
        disp.valid <= sp_valid;
      end
      if (take) begin
        digit_codes <= digit_codes_next;
        scan_pos    <= scan_pos_next;
        dwell_count <= dwell_count_next;
      end
    end
    if (take) begin
      disp.segments     <= fdssd_pkg::seg_of(digit_codes_next[scan_pos_next]);
      disp.digit_index  <= scan_pos_next;
      disp.digit_enable <= 1'b1;
    end
  end

endmodule

[sim/tb_top.sv]
// Self-checking bench for four_digit_seven_segment_driver_unit: directed and
// random command traffic against a cycle-free predictor of the display state.
// Depends on fdssd_pkg, fdssd_cmd_if, fdssd_disp_if and the driver RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code that the driver ignores apart from reporting
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Cycles with no command or display transaction before the run is called hung
  localparam int QUIET_LIMIT = 2000;
  // Extra settling wait after the last expected frame has been displayed
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [7:0] segments;
    logic [1:0] digit_index;
    logic       digit_enable;
  } display_frame_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  fdssd_cmd_if  cmd_ch ();
  fdssd_disp_if disp_ch ();

  four_digit_seven_segment_driver_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .disp      (disp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted driver state
  logic [13:0] disp_show_limit;
  logic [15:0] disp_dwell;
  logic [3:0]  digit_store [fdssd_pkg::DIGIT_COUNT];
  logic [1:0]  scan_digit;
  logic [15:0] scan_ticks;

  display_frame_t expected_frames [$];

  int  src_idle_pct   = 0;
  int  sink_stall_pct = 0;
  int  sink_hold      = 0;
  int  quiet_cycles   = 0;
  int  items_sent     = 0;
  int  frames_checked = 0;
  int  cmd_stalls     = 0;
  bit  failed         = 1'b0;

  // Segment pattern of one digit code, bit0 A .. bit6 G, point never lit
  function automatic logic [7:0] segment_pattern(input logic [3:0] code);
    case (code)
      4'd0:              return 8'h3F;
      4'd1:              return 8'h06;
      4'd2:              return 8'h5B;
      4'd3:              return 8'h4F;
      4'd4:              return 8'h66;
      4'd5:              return 8'h6D;
      4'd6:              return 8'h7D;
      4'd7:              return 8'h07;
      4'd8:              return 8'h7F;
      4'd9:              return 8'h6F;
      fdssd_pkg::CODE_E: return 8'h79;
      fdssd_pkg::CODE_F: return 8'h71;
      fdssd_pkg::CODE_R: return 8'h50;
      default:           return 8'h00;
    endcase
  endfunction

  // Apply one command to the predicted state and return the frame it shows
  function automatic display_frame_t next_frame(input logic [1:0] op,
                                                input logic [15:0] v);
    logic [15:0] shown_limit;
    logic [15:0] dwell_limit;
    logic [15:0] ticks_next;
    display_frame_t f;
    case (op)
      fdssd_pkg::CMD_TICK: begin
        dwell_limit = (disp_dwell == 16'd0) ? 16'd1 : disp_dwell;
        ticks_next  = scan_ticks + 16'd1;
        if (ticks_next == 16'd0 || ticks_next >= dwell_limit) begin
          scan_ticks = 16'd0;
          scan_digit = scan_digit + 2'd1;
        end else begin
          scan_ticks = ticks_next;
        end
      end
      fdssd_pkg::CMD_SHOW: begin
        shown_limit = (disp_show_limit > fdssd_pkg::MAX_SHOWN) ? 16'(fdssd_pkg::MAX_SHOWN)
                                                                : 16'(disp_show_limit);
        if (v <= shown_limit) begin
          digit_store[0] = (v > 16'd999) ? 4'((v / 1000) % 10) : fdssd_pkg::CODE_BLANK;
          digit_store[1] = (v > 16'd99)  ? 4'((v / 100) % 10)  : fdssd_pkg::CODE_BLANK;
          digit_store[2] = (v > 16'd9)   ? 4'((v / 10) % 10)   : fdssd_pkg::CODE_BLANK;
          digit_store[3] = 4'(v % 10);
        end else begin
          digit_store[0] = fdssd_pkg::CODE_E;
          digit_store[1] = fdssd_pkg::CODE_R;
          digit_store[2] = fdssd_pkg::CODE_R;
          digit_store[3] = fdssd_pkg::CODE_BLANK;
        end
      end
      fdssd_pkg::CMD_BLANK: begin
        foreach (digit_store[i]) digit_store[i] = fdssd_pkg::CODE_BLANK;
      end
      default: ;
    endcase
    f.segments     = segment_pattern(digit_store[scan_digit]);
    f.digit_index  = scan_digit;
    f.digit_enable = 1'b1;
    return f;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Display receiver: long hold-off when requested, else random stalls
  initial begin
    disp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        disp_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        disp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Predict on accepted commands and register writes, check displayed frames
  always @(posedge clk) begin : monitor
    display_frame_t got;
    display_frame_t want;
    logic moved;
    moved = 1'b0;
    if (rst) begin
      disp_show_limit = fdssd_pkg::SHOW_LIMIT_RESET;
      disp_dwell      = fdssd_pkg::DWELL_RESET;
      foreach (digit_store[i]) digit_store[i] = fdssd_pkg::CODE_BLANK;
      scan_digit = '0;
      scan_ticks = '0;
      expected_frames.delete();
    end else begin
      if (disp_ch.valid && disp_ch.ready) begin
        moved            = 1'b1;
        got.segments     = disp_ch.segments;
        got.digit_index  = disp_ch.digit_index;
        got.digit_enable = disp_ch.digit_enable;
        if (expected_frames.size() == 0) begin
          $error("display transaction with none pending: segments %h index %0d enable %0b",
                 got.segments, got.digit_index, got.digit_enable);
          failed = 1'b1;
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (got.segments !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, got.segments);
            failed = 1'b1;
          end
          if (got.digit_index !== want.digit_index) begin
            $error("digit_index: expected %0d, got %0d", want.digit_index,
                   got.digit_index);
            failed = 1'b1;
          end
          if (got.digit_enable !== want.digit_enable) begin
            $error("digit_enable: expected %0b, got %0b", want.digit_enable,
                   got.digit_enable);
            failed = 1'b1;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        moved = 1'b1;
        items_sent++;
        expected_frames.push_back(next_frame(cmd_ch.command, cmd_ch.value));
      end else if (cmd_ch.valid) begin
        cmd_stalls++;
      end
      if (cfg_we) begin
        if (cfg_index == fdssd_pkg::CFG_SHOW_LIMIT) disp_show_limit = cfg_data[13:0];
        else                                        disp_dwell      = cfg_data;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog on channel activity
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Offer one command; returns just after the edge that accepts it
  task automatic send_item(input logic [1:0] op, input logic [15:0] v);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.value   <= v;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Drop valid and wait until every pending frame has been displayed
  task automatic settle_display();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random command: mostly ticks and shows; values up to the limit, at or just above it, fully random or below 100
  task automatic send_random_item(input int max_cfg);
    int lim;
    int pick;
    logic [1:0]  op;
    logic [15:0] v;
    lim  = (max_cfg > fdssd_pkg::MAX_SHOWN) ? fdssd_pkg::MAX_SHOWN : max_cfg;
    pick = $urandom_range(99);
    if (pick < 45)      op = fdssd_pkg::CMD_TICK;
    else if (pick < 85) op = fdssd_pkg::CMD_SHOW;
    else if (pick < 95) op = fdssd_pkg::CMD_BLANK;
    else                op = CMD_UNUSED;
    case ($urandom_range(3))
      0:       v = 16'($urandom_range(lim));
      1:       v = 16'($urandom);
      2:       v = 16'(lim + $urandom_range(1));
      default: v = 16'($urandom_range(99));
    endcase
    send_item(op, v);
  endtask

  // One traffic phase: set registers while idle, then random commands
  task automatic run_traffic_phase(input int n, input int max_cfg, input int dwell_cfg,
                                   input int src_pct, input int sink_pct);
    settle_display();
    write_register(fdssd_pkg::CFG_SHOW_LIMIT, 16'(max_cfg));
    write_register(fdssd_pkg::CFG_DWELL_TICKS, 16'(dwell_cfg));
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n) send_random_item(max_cfg);
    settle_display();
  endtask

  // Digit split boundaries, error pattern, unused command, limit and dwell corners
  task automatic test_directed();
    send_item(fdssd_pkg::CMD_SHOW, 16'd0);
    send_item(fdssd_pkg::CMD_SHOW, 16'd9);
    send_item(fdssd_pkg::CMD_SHOW, 16'd10);
    send_item(fdssd_pkg::CMD_SHOW, 16'd99);
    send_item(fdssd_pkg::CMD_SHOW, 16'd100);
    send_item(fdssd_pkg::CMD_SHOW, 16'd999);
    send_item(fdssd_pkg::CMD_SHOW, 16'd1000);
    send_item(fdssd_pkg::CMD_SHOW, 16'd9999);
    send_item(fdssd_pkg::CMD_SHOW, 16'd10000);
    send_item(fdssd_pkg::CMD_SHOW, 16'hFFFF);
    send_item(fdssd_pkg::CMD_TICK, 16'd0);
    send_item(CMD_UNUSED, 16'hFFFF);
    send_item(fdssd_pkg::CMD_BLANK, 16'd0);
    send_item(fdssd_pkg::CMD_SHOW, 16'd1234);
    settle_display();
    // Limit register above four digits, zero dwell advancing every tick
    write_register(fdssd_pkg::CFG_SHOW_LIMIT, 16'hFFFF);
    write_register(fdssd_pkg::CFG_DWELL_TICKS, 16'd0);
    send_item(fdssd_pkg::CMD_SHOW, 16'd9999);
    send_item(fdssd_pkg::CMD_SHOW, 16'd10000);
    send_item(fdssd_pkg::CMD_SHOW, 16'd4321);
    repeat (4) send_item(fdssd_pkg::CMD_TICK, 16'hFFFF);
    send_item(fdssd_pkg::CMD_BLANK, 16'd0);
    send_item(fdssd_pkg::CMD_TICK, 16'd0);
    send_item(fdssd_pkg::CMD_SHOW, 16'd7);
    send_item(fdssd_pkg::CMD_TICK, 16'd0);
    settle_display();
  endtask

  // Register corners crossed with the four idling patterns
  task automatic test_random_traffic();
    run_traffic_phase(200, 9999, 1, 0, 0);
    run_traffic_phase(150, 0, 0, 74, 0);
    run_traffic_phase(200, 16383, 3, 0, 74);
    run_traffic_phase(150, 1, 65535, 14, 14);
    run_traffic_phase(200, $urandom_range(2, 9998), 2, 0, 0);
    run_traffic_phase(150, 10000, $urandom_range(1, 7), 74, 0);
    run_traffic_phase(200, 500, 4, 0, 74);
    run_traffic_phase(200, 9999, 100, 14, 14);
  endtask

  // Hold the display output off so the pipeline fills and stalls commands
  task automatic test_backpressure();
    settle_display();
    write_register(fdssd_pkg::CFG_SHOW_LIMIT, 16'd9999);
    write_register(fdssd_pkg::CFG_DWELL_TICKS, 16'd2);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold      = 64;
    repeat (40) send_random_item(9999);
    settle_display();
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = fdssd_pkg::CFG_SHOW_LIMIT;
    cfg_data       = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = fdssd_pkg::CMD_TICK;
    cmd_ch.value   = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic();
    test_backpressure();

    if (expected_frames.size() != 0) begin
      $error("%0d display frames never arrived", expected_frames.size());
      failed = 1'b1;
    end
    $display("Ran %0d commands and checked %0d display frames across eight register",
             items_sent, frames_checked);
    $display("settings and idling patterns; command input stalled %0d cycles.",
             cmd_stalls);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fdssd_pkg.sv
hw/rtl/fdssd_cmd_if.sv
hw/rtl/fdssd_disp_if.sv
hw/rtl/fdssd_split.sv
hw/rtl/four_digit_seven_segment_driver_unit.sv
sim/tb_top.sv
